>>> rtl/core/pva_pkg.sv
package pva_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam logic [6:0] OCTAVE = 7'd12;

    localparam logic [2:0] MODE_MONO    = 3'd0;
    localparam logic [2:0] MODE_LOWEST  = 3'd1;
    localparam logic [2:0] MODE_NEWEST  = 3'd2;
    localparam logic [2:0] MODE_ROUND   = 3'd3;
    localparam logic [2:0] MODE_HIGHEST = 3'd4;

    localparam logic OP_NOTE_ON  = 1'b0;
    localparam logic OP_NOTE_OFF = 1'b1;

    localparam logic [1:0] REG_ALLOC_MODE = 2'd0;
    localparam logic [1:0] REG_THIRD_ON   = 2'd1;
    localparam logic [1:0] REG_SUB_OCT    = 2'd2;

    typedef struct packed {
        logic       operation;
        logic [6:0] key_note;
        logic [6:0] key_velocity;
    } event_t;

    typedef struct packed {
        logic [6:0] osc1_note;
        logic [6:0] osc2_note;
        logic [6:0] voice_velocity;
        logic       gate;
        logic       retrigger;
        logic       ext_off_valid;
        logic [6:0] ext_off_note;
        logic       ext_on_valid;
        logic [6:0] ext_on_note;
        logic [6:0] ext_on_velocity;
    } result_t;

    typedef struct packed {
        logic [2:0] alloc_mode;
        logic       third_voice_on;
        logic       sub_octave_on;
    } cfg_t;

endpackage

>>> rtl/core/pva_if.sv
interface pva_event_if;
    logic             valid;
    logic             ready;
    pva_pkg::event_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pva_result_if;
    logic             valid;
    logic             ready;
    pva_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/pva_cfg.sv
module pva_cfg (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    output pva_pkg::cfg_t cfg
);
    logic [2:0] mode_reg;
    logic       third_reg;
    logic       sub_reg;
    logic       wr;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 3'd0;
            third_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else if (wr)
        begin
            case (idx)
                pva_pkg::REG_ALLOC_MODE: mode_reg <= pwdata[2:0];
                pva_pkg::REG_THIRD_ON:   third_reg <= pwdata[0];
                pva_pkg::REG_SUB_OCT:    sub_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            pva_pkg::REG_ALLOC_MODE: prdata = {29'd0, mode_reg};
            pva_pkg::REG_THIRD_ON:   prdata = {31'd0, third_reg};
            pva_pkg::REG_SUB_OCT:    prdata = {31'd0, sub_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    assign cfg.alloc_mode = mode_reg;
    assign cfg.third_voice_on = third_reg;
    assign cfg.sub_octave_on = sub_reg;
endmodule

>>> rtl/core/pva_core.sv
// Sequencer over the held-note stack memory. One read port is shared by the
// match search, the gap close and the voice selection scans.
module pva_core #(
    parameter int STACK_DEPTH = pva_pkg::STACK_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  pva_pkg::cfg_t cfg,
    pva_event_if.sink     ev,
    pva_result_if.source  res
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_FIND   = 8'b00000010,
        S_SHIFT  = 8'b00000100,
        S_ALLOC  = 8'b00001000,
        S_SCAN   = 8'b00010000,
        S_PICK   = 8'b00100000,
        S_FINISH = 8'b01000000,
        S_OUT    = 8'b10000000
    } state_t;

    logic [13:0] mem [STACK_DEPTH];

    state_t     state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] ptr_reg;        // scan index, may equal the count
    logic [13:0]   rd_reg;
    logic [1:0]    rot_reg;
    logic [6:0]    ext_note_reg;
    logic          ext_valid_reg;
    logic [6:0]    osc1_reg, osc2_reg, vel_reg;
    logic [6:0]    key_reg;
    pva_pkg::result_t res_reg;
    logic          res_valid_reg;
    logic          retrig_reg;
    logic [1:0]    slot_reg;       // voice being filled
    logic [1:0]    nvoice_reg;     // voices to fill
    logic [2:0]    used_reg;       // round robin voices taken
    logic [CW-1:0] skip_reg;       // sorted rank being selected
    logic [6:0]    best_reg;
    logic          best_ok_reg;
    logic [CW-1:0] best_idx_reg;
    logic [CW-1:0] prev_idx_reg;   // index of last picked entry
    logic [6:0]    prev_note_reg;
    logic          rd_phase_reg;
    logic          on_valid_reg;
    logic [6:0]    on_note_reg, on_vel_reg;

    logic [1:0] voices;
    logic       desc;
    logic [1:0] first_v;
    logic [6:0] sub_n;

    assign voices = cfg.third_voice_on ? 2'd3 : 2'd2;
    assign desc = (cfg.alloc_mode == pva_pkg::MODE_HIGHEST);
    assign first_v = (rot_reg >= voices) ? rot_reg - voices : rot_reg;

    function automatic logic [6:0] shift_sub(input logic on, input logic [6:0] n);
        return (on && n >= pva_pkg::OCTAVE) ? n - pva_pkg::OCTAVE : n;
    endfunction

    assign ev.ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign res.valid = res_valid_reg;
    assign res.data = res_reg;

    // A candidate beats the best one so far if it sorts strictly after the
    // previously picked (note, index) key and strictly before the best one.
    logic [6:0] cn;
    logic       after_prev, before_best;
    assign cn = rd_reg[13:7];
    always_comb
    begin
        if (skip_reg == '0)
            after_prev = 1'b1;
        else if (cn == prev_note_reg)
            after_prev = ptr_reg > prev_idx_reg;
        else
            after_prev = desc ? (cn < prev_note_reg) : (cn > prev_note_reg);
        if (!best_ok_reg)
            before_best = 1'b1;
        else
            before_best = desc ? (cn > best_reg) : (cn < best_reg);
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[ptr_reg[AW-1:0]];
        if (state_reg == S_IDLE && ev.valid && ev.ready &&
            ev.data.operation == pva_pkg::OP_NOTE_ON &&
            count_reg < CW'(STACK_DEPTH))
            mem[count_reg[AW-1:0]] <= {ev.data.key_note, ev.data.key_velocity};
        else if (state_reg == S_SHIFT && rd_phase_reg)
            mem[ptr_reg[AW-1:0] - AW'(1)] <= rd_reg;
    end

    logic [1:0] free_v;
    always_comb
    begin
        if (!used_reg[0])
            free_v = 2'd0;
        else if (!used_reg[1])
            free_v = 2'd1;
        else
            free_v = 2'd2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rot_reg       <= 2'd0;
            ext_note_reg  <= 7'd0;
            ext_valid_reg <= 1'b0;
            osc1_reg      <= 7'd0;
            osc2_reg      <= 7'd0;
            vel_reg       <= 7'd0;
            res_valid_reg <= 1'b0;
            ptr_reg       <= '0;
            rd_phase_reg  <= 1'b0;
            key_reg       <= 7'd0;
            res_reg       <= '0;
            retrig_reg    <= 1'b0;
            slot_reg      <= 2'd0;
            nvoice_reg    <= 2'd0;
            used_reg      <= 3'd0;
            skip_reg      <= '0;
            best_reg      <= 7'd0;
            best_ok_reg   <= 1'b0;
            best_idx_reg  <= '0;
            prev_idx_reg  <= '0;
            prev_note_reg <= 7'd0;
            on_valid_reg  <= 1'b0;
            on_note_reg   <= 7'd0;
            on_vel_reg    <= 7'd0;
        end
        else
        begin
            if (res.valid && res.ready)
                res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (ev.valid && ev.ready)
                    begin
                        key_reg <= ev.data.key_note;
                        retrig_reg <= 1'b0;
                        ptr_reg <= '0;
                        rd_phase_reg <= 1'b0;
                        if (ev.data.operation == pva_pkg::OP_NOTE_ON)
                        begin
                            if (count_reg < CW'(STACK_DEPTH))
                            begin
                                count_reg <= count_reg + CW'(1);
                                retrig_reg <= (cfg.alloc_mode == pva_pkg::MODE_MONO) ||
                                              (count_reg == '0);
                            end
                            else
                                retrig_reg <= (cfg.alloc_mode == pva_pkg::MODE_MONO) ||
                                              (count_reg == CW'(1));
                            state_reg <= S_ALLOC;
                        end
                        else
                            state_reg <= S_FIND;
                    end
                end
                S_FIND:
                begin
                    // Address issued in one cycle, data compared in the next.
                    if (!rd_phase_reg)
                    begin
                        if (ptr_reg >= count_reg)
                            state_reg <= S_ALLOC;
                        else
                            rd_phase_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_phase_reg <= 1'b0;
                        ptr_reg <= ptr_reg + CW'(1);
                        if (rd_reg[13:7] == key_reg)
                            state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    // ptr points one past the removed entry: copy down.
                    if (!rd_phase_reg)
                    begin
                        if (ptr_reg >= count_reg)
                        begin
                            count_reg <= count_reg - CW'(1);
                            state_reg <= S_ALLOC;
                        end
                        else
                            rd_phase_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_phase_reg <= 1'b0;
                        ptr_reg <= ptr_reg + CW'(1);
                    end
                end
                S_ALLOC:
                begin
                    res_reg.ext_off_valid <= ext_valid_reg;
                    res_reg.ext_off_note <= ext_valid_reg ? ext_note_reg : 7'd0;
                    ext_valid_reg <= 1'b0;
                    on_valid_reg <= 1'b0;
                    on_note_reg <= 7'd0;
                    on_vel_reg <= 7'd0;
                    slot_reg <= 2'd0;
                    skip_reg <= '0;
                    best_ok_reg <= 1'b0;
                    rd_phase_reg <= 1'b0;
                    used_reg <= 3'd0;
                    nvoice_reg <= (count_reg < CW'(voices)) ? count_reg[1:0] : voices;
                    if (count_reg == '0 || cfg.alloc_mode > pva_pkg::MODE_HIGHEST)
                        state_reg <= S_FINISH;
                    else if (cfg.alloc_mode == pva_pkg::MODE_MONO || count_reg == CW'(1))
                    begin
                        ptr_reg <= count_reg - CW'(1);
                        if (cfg.alloc_mode == pva_pkg::MODE_ROUND)
                            rot_reg <= 2'd0;
                        nvoice_reg <= 2'd0;
                        state_reg <= S_PICK;
                    end
                    else if (cfg.alloc_mode == pva_pkg::MODE_LOWEST ||
                             cfg.alloc_mode == pva_pkg::MODE_HIGHEST)
                    begin
                        ptr_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        ptr_reg <= count_reg - CW'(1);
                        if (cfg.alloc_mode == pva_pkg::MODE_ROUND)
                        begin
                            slot_reg <= first_v;
                            rot_reg <= (first_v + 2'd1 == voices) ? 2'd0 : first_v + 2'd1;
                        end
                        state_reg <= S_PICK;
                    end
                end
                S_SCAN:
                begin
                    // Selection sort: one pass per voice finds the next key.
                    if (!rd_phase_reg)
                    begin
                        if (ptr_reg >= count_reg)
                        begin
                            ptr_reg <= best_idx_reg;
                            state_reg <= S_PICK;
                        end
                        else
                            rd_phase_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_phase_reg <= 1'b0;
                        if (after_prev && before_best)
                        begin
                            best_reg <= cn;
                            best_ok_reg <= 1'b1;
                            best_idx_reg <= ptr_reg;
                        end
                        ptr_reg <= ptr_reg + CW'(1);
                    end
                end
                S_PICK:
                begin
                    if (!rd_phase_reg)
                        rd_phase_reg <= 1'b1;
                    else
                    begin
                        rd_phase_reg <= 1'b0;
                        if (nvoice_reg == 2'd0)
                        begin
                            // Both oscillators play one note.
                            osc1_reg <= rd_reg[13:7];
                            vel_reg <= rd_reg[6:0];
                            osc2_reg <= shift_sub(cfg.sub_octave_on, rd_reg[13:7]);
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            case (slot_reg)
                                2'd0:
                                begin
                                    osc1_reg <= rd_reg[13:7];
                                    vel_reg <= rd_reg[6:0];
                                end
                                2'd1: osc2_reg <= shift_sub(cfg.sub_octave_on, rd_reg[13:7]);
                                default:
                                begin
                                    on_valid_reg <= 1'b1;
                                    on_note_reg <= rd_reg[13:7];
                                    on_vel_reg <= rd_reg[6:0];
                                    ext_note_reg <= rd_reg[13:7];
                                    ext_valid_reg <= 1'b1;
                                end
                            endcase
                            nvoice_reg <= nvoice_reg - 2'd1;
                            used_reg[slot_reg] <= 1'b1;
                            if (nvoice_reg == 2'd1)
                                state_reg <= S_FINISH;
                            else if (cfg.alloc_mode == pva_pkg::MODE_LOWEST ||
                                     cfg.alloc_mode == pva_pkg::MODE_HIGHEST)
                            begin
                                prev_note_reg <= rd_reg[13:7];
                                prev_idx_reg <= ptr_reg;
                                skip_reg <= skip_reg + CW'(1);
                                best_ok_reg <= 1'b0;
                                slot_reg <= slot_reg + 2'd1;
                                ptr_reg <= '0;
                                state_reg <= S_SCAN;
                            end
                            else
                            begin
                                ptr_reg <= ptr_reg - CW'(1);
                                if (cfg.alloc_mode == pva_pkg::MODE_ROUND)
                                begin
                                    if (slot_reg != 2'd0 && !used_reg[0])
                                        slot_reg <= 2'd0;
                                    else if (slot_reg != 2'd1 && !used_reg[1])
                                        slot_reg <= 2'd1;
                                    else
                                        slot_reg <= free_v == slot_reg ? 2'd2 : free_v;
                                end
                                else
                                    slot_reg <= slot_reg + 2'd1;
                            end
                        end
                    end
                end
                S_FINISH:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    res_reg.osc1_note <= osc1_reg;
                    res_reg.osc2_note <= osc2_reg;
                    res_reg.voice_velocity <= vel_reg;
                    res_reg.gate <= (count_reg != '0);
                    res_reg.retrigger <= retrig_reg;
                    res_reg.ext_on_valid <= on_valid_reg;
                    res_reg.ext_on_note <= on_note_reg;
                    res_reg.ext_on_velocity <= on_vel_reg;
                    res_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/paraphonic_voice_allocator.sv
// From acceptance to result, a note off walks the stack entry by entry, and sorted
// modes scan the stack once per voice.
// Throughput: one item at a time; ready is low from acceptance until result is taken.
// The single-port stack memory sets these limits.
// Reset: rst_n clears all control and configuration state; stack is not cleared.
module paraphonic_voice_allocator #(
    parameter int STACK_DEPTH = pva_pkg::STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pva_event_if.sink    ev,
    pva_result_if.source res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    pva_pkg::cfg_t cfg;

    pva_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    pva_core #(.STACK_DEPTH(STACK_DEPTH)) u_core (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .ev(ev), .res(res)
    );
endmodule
